// File: hw/rtl/fdr_pkg.sv
// shared types and constants of the feedback delay reverb
package fdr_pkg;

   localparam int RING_SIZE_W = 18;
   localparam int GAIN_W      = 16;
   localparam int GAIN_SHIFT  = 15;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 2;

   localparam logic [REG_IDX_W-1:0] REG_RING_SIZE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DAMP_GAIN = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WET_GAIN  = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DRY_GAIN  = 2'd3;

   localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = 18'd1024;
   localparam logic [GAIN_W-1:0]      DAMP_GAIN_RST = 16'd16384;
   localparam logic [GAIN_W-1:0]      WET_GAIN_RST  = 16'd16384;
   localparam logic [GAIN_W-1:0]      DRY_GAIN_RST  = 16'd32768;

   typedef struct packed {
      logic [RING_SIZE_W-1:0] ring_size;
      logic [GAIN_W-1:0]      damp_gain;
      logic [GAIN_W-1:0]      wet_gain;
      logic [GAIN_W-1:0]      dry_gain;
   } cfg_type;

   typedef struct packed {
      logic clr_step;
      logic take;
      logic rd;
      logic echo;
      logic mix;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/fdr_channels.sv
// word channels of the reverb: sample request and mixed sample response
interface fdr_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);
endinterface

interface fdr_rsp_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);
endinterface

// File: hw/rtl/feedback_delay_reverb.sv
// top level of the feedback comb filter reverb
//
// Usage: one signed sample word enters on req_ch (valid/ready) and one mixed
// sample word leaves on rsp_ch (valid/ready) for every word taken. Gains and
// the ring length are set through the apb-style port (psel/penable/pwrite,
// registers at byte addresses 0, 4, 8, 12: ring size, damp, wet, dry gain);
// write them only while no word is in flight. pready is always high.
// Sequence: a word taken in the idle step runs through the controller's
// steps of ring address and read, echo multiply, mix multiply with ring
// write, and output load onto rsp_ch, which waits until the output
// register is free; no new word is taken before the last one is loaded
// there. The ring memory read and write fall in different steps.
// Reset: synchronous, active high. After reset the ring memory is swept to
// zero one entry a cycle, all MAX_RING_DEPTH entries, with req_ch ready low;
// configuration writes are taken during the sweep.
// Stall: a result held in the output register while rsp_ch.ready is low
// does not block the next word from being taken; the sequence waits at its
// output step until the register is free.
module feedback_delay_reverb
   import fdr_pkg::*;
#(
   parameter int MAX_RING_DEPTH = 131072,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   fdr_req_if.sink               req_ch,
   fdr_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   fdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fdr_dp #(
      .MAX_RING_DEPTH (MAX_RING_DEPTH),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .in_sample  (req_ch.in_sample),
      .out_sample (rsp_ch.out_sample),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready)
   );

endmodule

// File: hw/rtl/fdr_csr.sv
// configuration registers behind the apb-style port
module fdr_csr
   import fdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [RING_SIZE_W-1:0] ring_size_ff;
   logic [GAIN_W-1:0]      damp_ff;
   logic [GAIN_W-1:0]      wet_ff;
   logic [GAIN_W-1:0]      dry_ff;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[REG_IDX_W+1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RST;
         damp_ff      <= DAMP_GAIN_RST;
         wet_ff       <= WET_GAIN_RST;
         dry_ff       <= DRY_GAIN_RST;
      end else if (wr_en) begin
         case (idx)
            REG_RING_SIZE: ring_size_ff <= pwdata[RING_SIZE_W-1:0];
            REG_DAMP_GAIN: damp_ff      <= pwdata[GAIN_W-1:0];
            REG_WET_GAIN:  wet_ff       <= pwdata[GAIN_W-1:0];
            REG_DRY_GAIN:  dry_ff       <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RING_SIZE: prdata = CSR_DATA_W'(ring_size_ff);
         REG_DAMP_GAIN: prdata = CSR_DATA_W'(damp_ff);
         REG_WET_GAIN:  prdata = CSR_DATA_W'(wet_ff);
         REG_DRY_GAIN:  prdata = CSR_DATA_W'(dry_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg.ring_size = ring_size_ff;
   assign cfg.damp_gain = damp_ff;
   assign cfg.wet_gain  = wet_ff;
   assign cfg.dry_gain  = dry_ff;

endmodule

// File: hw/rtl/fdr_dp.sv
// datapath: delay ring memory, address math, gain multipliers, output register
module fdr_dp
   import fdr_pkg::*;
#(
   parameter int MAX_RING_DEPTH = 131072,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  cfg_type                        cfg,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   output logic signed [SAMPLE_WIDTH-1:0] out_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int AW   = $clog2(MAX_RING_DEPTH);
   localparam int SZW  = AW + 1;
   localparam int CMPW = (RING_SIZE_W > SZW) ? RING_SIZE_W : SZW;
   localparam int EW   = SW + GAIN_W + 1 - GAIN_SHIFT;   // echo width
   localparam int WW   = EW + GAIN_W + 1 - GAIN_SHIFT;   // scaled echo width
   localparam int MW   = WW + 1;                         // mix sum width

   logic signed [SW-1:0] mem [MAX_RING_DEPTH];

   logic [AW-1:0]        clr_ff;
   logic [AW-1:0]        wp_ff;
   logic signed [SW-1:0] sample_ff;
   logic signed [SW-1:0] rd_data_ff;
   logic signed [EW-1:0] echo_ff;
   logic signed [EW-1:0] dry_ff;
   logic signed [WW-1:0] wet_ff;
   logic signed [SW-1:0] out_ff;
   logic                 rsp_valid_ff;

   logic [SZW-1:0]         size;
   logic [SZW:0]           size_p1;
   logic [SZW-1:0]         half_up;
   logic [SZW-1:0]         rd_sum;
   logic [SZW-1:0]         rd_full;
   logic [AW-1:0]          rd_addr;
   logic [SZW-1:0]         wp_next;
   logic [AW-1:0]          wp_adv;
   logic [AW-1:0]          wp_norm;
   logic signed [SW+GAIN_W:0] echo_prod;
   logic signed [SW+GAIN_W:0] dry_prod;
   logic signed [EW+GAIN_W:0] wet_prod;
   logic signed [EW:0]     store_sum;
   logic signed [SW-1:0]   store_sat;
   logic signed [MW-1:0]   mix_sum;
   logic signed [SW-1:0]   mix_sat;

   // effective ring size: zero acts as one, large values clamp to the depth
   always_comb begin
      if (cfg.ring_size == '0) begin
         size = SZW'(1);
      end else if (CMPW'(cfg.ring_size) > CMPW'(MAX_RING_DEPTH)) begin
         size = SZW'(MAX_RING_DEPTH);
      end else begin
         size = SZW'(cfg.ring_size);
      end
   end

   // size minus floor(size/2) is ceil(size/2)
   assign size_p1 = {1'b0, size} + (SZW+1)'(1);
   assign half_up = size_p1[SZW:1];

   assign wp_norm = ({1'b0, wp_ff} >= size) ? '0 : wp_ff;

   assign rd_sum  = SZW'(wp_ff) + half_up;
   assign rd_full = (rd_sum >= size) ? (rd_sum - size) : rd_sum;
   assign rd_addr = rd_full[AW-1:0];

   assign wp_next = SZW'(wp_ff) + SZW'(1);
   assign wp_adv  = (wp_next == size) ? '0 : wp_next[AW-1:0];

   assign echo_prod = rd_data_ff * $signed({1'b0, cfg.damp_gain});
   assign dry_prod  = sample_ff * $signed({1'b0, cfg.dry_gain});
   assign wet_prod  = echo_ff * $signed({1'b0, cfg.wet_gain});

   assign store_sum = (EW+1)'(sample_ff) + (EW+1)'(echo_ff);
   assign store_sat = (&store_sum[EW:SW-1] || ~|store_sum[EW:SW-1])
                    ? store_sum[SW-1:0]
                    : {store_sum[EW], {(SW-1){~store_sum[EW]}}};

   assign mix_sum = MW'(dry_ff) + MW'(wet_ff);
   assign mix_sat = (&mix_sum[MW-1:SW-1] || ~|mix_sum[MW-1:SW-1])
                  ? mix_sum[SW-1:0]
                  : {mix_sum[MW-1], {(SW-1){~mix_sum[MW-1]}}};

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mix) begin
         mem[wp_ff] <= store_sat;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.take) begin
            wp_ff <= wp_norm;
         end else if (cmd.mix) begin
            wp_ff <= wp_adv;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= in_sample;
      end
      if (cmd.echo) begin
         echo_ff <= $signed(echo_prod[SW+GAIN_W:GAIN_SHIFT]);
      end
      if (cmd.mix) begin
         dry_ff <= $signed(dry_prod[SW+GAIN_W:GAIN_SHIFT]);
         wet_ff <= $signed(wet_prod[EW+GAIN_W:GAIN_SHIFT]);
      end
      if (cmd.emit) begin
         out_ff <= mix_sat;
      end
   end

   assign status.clr_last = (clr_ff == AW'(MAX_RING_DEPTH - 1));
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign out_sample      = out_ff;

   a_rd_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> ({1'b0, rd_addr} < size))
      else $error("ring read address outside the ring");

   a_wr_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |-> ({1'b0, wp_ff} < size))
      else $error("ring write position outside the ring");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("output register overwritten while stalled");

endmodule

// File: hw/rtl/fdr_ctrl.sv
// controller: clearing pass after reset and the per-word sequence
module fdr_ctrl
   import fdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_MIX   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.rd   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.echo = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_take_to_out: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> ##4 (state_ff == ST_OUT))
      else $error("word did not reach the output step on time");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass entered again");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !req_ready)
      else $error("new word taken while one is in flight");

endmodule
